// File: hdl/aescc_pkg.sv
// Package for the AES CBC/CTR block: state encodings, register indexes,
// S-box tables and the round functions. No dependencies.
`timescale 1ns / 1ps
package aescc_pkg;

  localparam int MAX_ROUNDS_DEF = 14;
  localparam int APB_AW = 6;
  localparam int APB_DW = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXP,
    S_PREP,
    S_RUN,
    S_OUT
  } aescc_state_t;

  typedef enum logic [2:0] {
    REG_KEY_SIZE,
    REG_CHAIN_MODE,
    REG_KEY_A,
    REG_KEY_B,
    REG_KEY_C,
    REG_KEY_D,
    REG_IV_HIGH,
    REG_IV_LOW
  } aescc_reg_t;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;
  localparam logic [1:0] MODE_CBC_ENC = 2'd0;
  localparam logic [1:0] MODE_CBC_DEC = 2'd1;

  localparam logic [7:0] RCON_FIRST = 8'h01;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte i of the block sits at bits [127-8i -: 8].
  function automatic logic [127:0] enc_round_core(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) t[i] = SBOX[s[127-8*i -: 8]];
    for (int row = 0; row < 4; row++)
      for (int c = 0; c < 4; c++) u[row+4*c] = t[row+4*((c+row)%4)];
    for (int c = 0; c < 4; c++) begin
      a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
      if (last) begin
        r[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127-32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        r[119-32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        r[111-32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        r[103-32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    enc_round_core = r;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [7:0] t [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) t[i] = s[127-8*i -: 8];
    for (int row = 0; row < 4; row++)
      for (int c = 0; c < 4; c++) r[127-8*(row+4*((c+row)%4)) -: 8] = INV_SBOX[t[row+4*c]];
    inv_shift_sub = r;
  endfunction

  function automatic logic [7:0] mul_9(input logic [7:0] a);
    mul_9 = xtime(xtime(xtime(a))) ^ a;
  endfunction

  function automatic logic [7:0] mul_11(input logic [7:0] a);
    mul_11 = xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
  endfunction

  function automatic logic [7:0] mul_13(input logic [7:0] a);
    mul_13 = xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
  endfunction

  function automatic logic [7:0] mul_14(input logic [7:0] a);
    mul_14 = xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8]; a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8]; a3 = s[103-32*c -: 8];
      r[127-32*c -: 8] = mul_14(a0) ^ mul_11(a1) ^ mul_13(a2) ^ mul_9(a3);
      r[119-32*c -: 8] = mul_9(a0) ^ mul_14(a1) ^ mul_11(a2) ^ mul_13(a3);
      r[111-32*c -: 8] = mul_13(a0) ^ mul_9(a1) ^ mul_14(a2) ^ mul_11(a3);
      r[103-32*c -: 8] = mul_11(a0) ^ mul_13(a1) ^ mul_9(a2) ^ mul_14(a3);
    end
    inv_mix = r;
  endfunction

endpackage

// File: hdl/aescc_if.sv
// Valid/ready channel interfaces for the input and result words.
// No dependencies.
`timescale 1ns / 1ps
interface aescc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        first_block;
  modport source (output valid, block_high, block_low, first_block, input ready);
  modport sink (input valid, block_high, block_low, first_block, output ready);
endinterface

interface aescc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

// File: hdl/aes_block_cipher_cbc_ctr.sv
// AES-128/192/256 block engine with CBC encrypt, CBC decrypt and CTR modes.
// Depends on aescc_pkg, aescc_if and aescc_ram.
//
// Usage: words enter on data_in (two 64-bit halves plus a first-block mark)
// and leave on data_out, one result word per input word. Registers are written
// over the APB port at byte address 8*i; the user must write them only while
// no word is in flight, as the block itself does not enforce it. After a key
// or key size write, the next word first expands the key, one 32-bit schedule
// word per cycle, 4*(Nr+1) words in all (44, 52 or 60). The round keys are
// kept in a RAM, one 128-bit round key per row, and read one row per cycle.
// After acceptance and any key expansion, each word passes through a prepare
// state for the state and chaining value, Nr+1 round steps on the shared
// round unit, one per cycle (Nr = 10, 12 or 14 rounds), and an output state
// that loads the result into the output register. The engine takes a word
// only in the idle state, so not before the last word's result is loaded.
// A new word is accepted when the engine is idle, even while a result still
// waits in the output register; the engine holds a finished result until
// that register frees.
// Reset clears the configuration registers and the chaining value to zero
// and marks the key schedule as stale. There is no RAM clearing pass.
`timescale 1ns / 1ps
module aes_block_cipher_cbc_ctr
  import aescc_pkg::*;
#(
  parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  aescc_in_if.sink          data_in,
  aescc_out_if.source       data_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);
  localparam int RKA = $clog2(MAX_ROUNDS + 1);
  localparam int WIW = RKA + 2;

  logic [1:0]  key_size, chain_mode;
  logic [63:0] key_word_a, key_word_b, key_word_c, key_word_d, iv_high, iv_low;
  logic        sched_ready;

  aescc_state_t state, state_next;
  logic [127:0] blk, st, chain, out_data;
  logic         first;
  logic         out_valid;
  logic [RKA-1:0] step;
  logic [WIW-1:0] wi;
  logic [2:0]     km;
  logic [7:0]     rcon;
  logic [31:0]    win [8];
  logic [31:0]    rowbuf [3];

  logic           cfg_wr;
  aescc_reg_t     cfg_idx;
  logic [3:0]     nk;
  logic [RKA-1:0] nr;
  logic [WIW-1:0] total_m1;
  logic           dec;
  logic           ctr;
  logic           in_acc;
  logic           out_free;

  logic           rk_we;
  logic [RKA-1:0] rk_waddr, rk_raddr;
  logic [127:0]   rk_wdata, rk;
  logic [31:0]    w_new, t_word;
  logic [255:0]   key_all;
  logic [127:0]   cv, cnt, st_round, dec_add;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = aescc_reg_t'(paddr[5:3]);

  always_comb begin
    unique case (aescc_reg_t'(paddr[5:3]))
      REG_KEY_SIZE:   prdata = {62'd0, key_size};
      REG_CHAIN_MODE: prdata = {62'd0, chain_mode};
      REG_KEY_A:      prdata = key_word_a;
      REG_KEY_B:      prdata = key_word_b;
      REG_KEY_C:      prdata = key_word_c;
      REG_KEY_D:      prdata = key_word_d;
      REG_IV_HIGH:    prdata = iv_high;
      REG_IV_LOW:     prdata = iv_low;
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    priority if (key_size == KS_128) begin
      nk = 4'd4;
    end else if (key_size == KS_192) begin
      nk = 4'd6;
    end else begin
      nk = 4'd8;
    end
  end
  assign nr       = (nk + 4'd6 > 4'(MAX_ROUNDS)) ? RKA'(MAX_ROUNDS) : RKA'(nk + 4'd6);
  assign total_m1 = WIW'({nr, 2'b11});
  assign dec      = (chain_mode == MODE_CBC_DEC);
  assign ctr      = !(chain_mode == MODE_CBC_ENC) && !dec;
  assign in_acc   = data_in.valid && data_in.ready;
  assign out_free = !out_valid || data_out.ready;

  // Key expansion word.
  assign key_all = {key_word_a, key_word_b, key_word_c, key_word_d};
  always_comb begin
    t_word = win[0];
    if (km == 3'd0) begin
      t_word = sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'd0};
    end else if (nk == 4'd8 && km == 3'd4) begin
      t_word = sub_word(win[0]);
    end
    if (wi < WIW'(nk)) begin
      w_new = key_all[255 - 32*wi[2:0] -: 32];
    end else begin
      w_new = win[3'(nk - 4'd1)] ^ t_word;
    end
  end

  // Round datapath.
  assign cv      = first ? {iv_high, iv_low} : chain;
  assign cnt     = first ? {iv_high, iv_low} : chain + 128'd1;
  assign dec_add = inv_shift_sub(st) ^ rk;
  always_comb begin
    if (step == '0) begin
      st_round = st ^ rk;
    end else if (dec) begin
      st_round = (step == nr) ? dec_add : inv_mix(dec_add);
    end else begin
      st_round = enc_round_core(st, step == nr) ^ rk;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc) state_next = sched_ready ? S_PREP : S_EXP;
      S_EXP:  if (wi == total_m1) state_next = S_PREP;
      S_PREP: state_next = S_RUN;
      S_RUN:  if (step == nr) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    data_in.ready = (state == S_IDLE);
    rk_we    = (state == S_EXP) && (wi[1:0] == 2'b11);
    rk_waddr = wi[WIW-1:2];
    rk_wdata = {rowbuf[0], rowbuf[1], rowbuf[2], w_new};
    rk_raddr = '0;
    if (state == S_PREP) begin
      rk_raddr = dec ? nr : '0;
    end else if (state == S_RUN) begin
      rk_raddr = dec ? nr - step - RKA'(1) : step + RKA'(1);
    end
  end

  aescc_ram #(.WIDTH(128), .DEPTH(MAX_ROUNDS + 1)) u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .raddr (rk_raddr),
    .rdata (rk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      key_size    <= '0;
      chain_mode  <= '0;
      key_word_a  <= '0;
      key_word_b  <= '0;
      key_word_c  <= '0;
      key_word_d  <= '0;
      iv_high     <= '0;
      iv_low      <= '0;
      sched_ready <= 1'b0;
      chain       <= '0;
      out_valid   <= 1'b0;
      step        <= '0;
      wi          <= '0;
      km          <= '0;
      rcon        <= RCON_FIRST;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_KEY_SIZE:   begin key_size <= pwdata[1:0]; sched_ready <= 1'b0; end
          REG_CHAIN_MODE: chain_mode <= pwdata[1:0];
          REG_KEY_A:      begin key_word_a <= pwdata; sched_ready <= 1'b0; end
          REG_KEY_B:      begin key_word_b <= pwdata; sched_ready <= 1'b0; end
          REG_KEY_C:      begin key_word_c <= pwdata; sched_ready <= 1'b0; end
          REG_KEY_D:      begin key_word_d <= pwdata; sched_ready <= 1'b0; end
          REG_IV_HIGH:    iv_high <= pwdata;
          REG_IV_LOW:     iv_low <= pwdata;
          default:        ;
        endcase
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (data_out.valid && data_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          wi   <= '0;
          km   <= '0;
          rcon <= RCON_FIRST;
        end
        S_EXP: begin
          wi <= wi + WIW'(1);
          km <= (km == 3'(nk - 4'd1)) ? 3'd0 : km + 3'd1;
          if (wi >= WIW'(nk) && km == 3'd0) rcon <= xtime(rcon);
          if (wi == total_m1) sched_ready <= 1'b1;
        end
        S_PREP: begin
          step  <= '0;
          chain <= ctr ? cnt : cv;
        end
        S_RUN: begin
          step <= step + RKA'(1);
        end
        S_OUT: begin
          if (out_free) begin
            if (dec) begin
              chain <= blk;
            end else if (!ctr) begin
              chain <= st;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      blk   <= {data_in.block_high, data_in.block_low};
      first <= data_in.first_block;
    end
    if (state == S_EXP) begin
      win[0] <= w_new;
      for (int k = 1; k < 8; k++) win[k] <= win[k-1];
      for (int k = 0; k < 3; k++) begin
        if (wi[1:0] == 2'(k)) rowbuf[k] <= w_new;
      end
    end
    if (state == S_PREP) begin
      if (ctr) begin
        st <= cnt;
      end else if (dec) begin
        st <= blk;
      end else begin
        st <= blk ^ cv;
      end
    end else if (state == S_RUN) begin
      st <= st_round;
    end
    if (state == S_OUT && out_free) begin
      if (dec) begin
        out_data <= st ^ chain;
      end else if (ctr) begin
        out_data <= blk ^ st;
      end else begin
        out_data <= st;
      end
    end
  end

  assign data_out.valid       = out_valid;
  assign data_out.result_high = out_data[127:64];
  assign data_out.result_low  = out_data[63:0];

  a_rk_write_in_exp: assert property (@(posedge clk) disable iff (rst)
    rk_we |-> state == S_EXP)
    else $error("round key RAM written outside key expansion");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result loaded outside the output state");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> step <= nr)
    else $error("round step past the round count");

  a_sched_after_exp: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP && state_next == S_PREP && !cfg_wr) |=> sched_ready)
    else $error("key schedule not marked ready after expansion");

endmodule

// File: hdl/aescc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module aescc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
